// ----- sv/pdqm_pkg.sv -----
`default_nettype none
package pdqm_pkg;

    // default table depth
    localparam int MAX_INTERVALS_DEF = 16;

    // stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 40;

    // serial divider widths
    localparam int DVD_W = 49;
    localparam int DVS_W = 32;

    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_QUANTILE = 2'd1,
        KIND_MODE     = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_CLAMPED = 3'd3,
        ST_ZERODIV = 3'd4
    } st_t;

    // one table entry
    typedef struct packed {
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        logic [16:0]        mass;
        logic [31:0]        height;
    } entry_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CLEAR,
        OP_SET_ST,
        OP_INS_START,
        OP_IDX_CLR,
        OP_RD_IDX,
        OP_IDX_INC,
        OP_SH_INIT,
        OP_RD_JM1,
        OP_SH_WR,
        OP_INS_WR,
        OP_Q_ACC,
        OP_Q_CLAMP,
        OP_GRAB,
        OP_RES_LOW,
        OP_Q_MUL,
        OP_DIV_Q,
        OP_RES_ADD,
        OP_M_SCAN,
        OP_RD_M,
        OP_RD_MM1,
        OP_RD_MP1,
        OP_MUL_H,
        OP_SUB_A,
        OP_SUB_P,
        OP_M_MUL,
        OP_DIV_M,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        st_t    st;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  empty;
        logic  ins_bad;
        logic  idx_at_cnt;
        logic  lo_gt_up;
        logic  lo_eq_up;
        logic  sh_done;
        logic  q_below;
        logic  idx_last;
        logic  mass_zero;
        logic  has_prev;
        logic  has_next;
        logic  dsum_zero;
        logic  div_idle;
        logic  out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- sv/piecewise_density_quantile_mode.sv -----
// Channel  Direction  tdata                                   tuser
// s_       in         lower_bound, upper_bound, probability,  kind
//                     quantile_level (104 bits, zero fill)
// m_       out        result_value, entry_count, status       -
//
// One item at a time. Insert runs the restoring divide for the height
// while the slot search and shift walk the table. Quantile and mode walk
// the table through its single read port and share the same divider.
// Reset (aresetn low, synchronous) empties the table and the output register.
// s_tready is high only while idle; a result waiting on m_tready holds the
// block in its last step.
`default_nettype none
module piecewise_density_quantile_mode #(
    parameter int MAX_INTERVALS = pdqm_pkg::MAX_INTERVALS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [31:0] lower_bound, [63:32] upper_bound, [80:64] probability,
    // [97:81] quantile_level, [103:98] zero
    input  wire logic [pdqm_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] kind
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [31:0] result_value, [36:32] entry_count, [39:37] status
    output logic [pdqm_pkg::M_TDATA_W-1:0]        m_tdata
);
    import pdqm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pdqm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdqm_dpath #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ----- sv/pdqm_div.sv -----
`default_nettype none
module pdqm_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [pdqm_pkg::DVD_W-1:0]   dividend,
    input  wire logic [pdqm_pkg::DVS_W-1:0]   divisor,
    output logic                              busy,
    output logic [pdqm_pkg::DVD_W-1:0]        quotient
);
    import pdqm_pkg::*;

    localparam int CNW = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic [CNW-1:0]   cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quot_reg;

    logic [DVS_W:0]   rem_sh;
    logic             ge;
    logic [DVS_W-1:0] rem_new;

    // one restoring step per cycle
    assign rem_sh  = {rem_reg, quot_reg[DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_new = ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CNW'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            cnt_reg  <= CNW'(DVD_W);
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[DVD_W-2:0], ge};
            rem_reg  <= rem_new;
            cnt_reg  <= cnt_reg - CNW'(1);
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

// ----- sv/pdqm_dpath.sv -----
`default_nettype none
module pdqm_dpath #(
    parameter int MAX_INTERVALS = pdqm_pkg::MAX_INTERVALS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire pdqm_pkg::cmd_t                   cmd,
    output pdqm_pkg::sts_t                        sts,
    input  wire logic [pdqm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [pdqm_pkg::M_TDATA_W-1:0]        m_tdata
);
    import pdqm_pkg::*;

    localparam int AW  = $clog2(MAX_INTERVALS);
    localparam int CW  = $clog2(MAX_INTERVALS + 1);
    localparam int ACW = 17 + AW;

    // captured item
    kind_t              kind_reg;
    logic signed [31:0] lo_reg;
    logic signed [31:0] hi_reg;
    logic [16:0]        pr_reg;
    logic [16:0]        p_reg;

    // walk state
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      j_reg;
    logic [AW-1:0]      m_reg;
    logic [31:0]        maxh_reg;
    logic [ACW-1:0]     acc_reg;
    logic [ACW-1:0]     flo_reg;

    // chosen interval and arithmetic
    logic signed [31:0] lowm_reg;
    logic [31:0]        w_reg;
    logic [16:0]        massm_reg;
    logic [16:0]        da_reg;
    logic [16:0]        dp_reg;
    logic [63:0]        prod_reg;

    logic [31:0]        res_reg;
    st_t                st_reg;
    logic               mval_reg;
    logic [M_TDATA_W-1:0] mdata_reg;

    // table memory
    entry_t             mem [MAX_INTERVALS];
    entry_t             rd_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;

    logic [31:0]        w_ins;
    logic [ACW-1:0]     acc_sum;
    logic [CW:0]        idx_p1;
    logic [CW:0]        m_p1;
    logic [47:0]        sub_h;
    logic [16:0]        d_next;
    logic [17:0]        dsum;
    logic [16:0]        pdiff;
    logic [31:0]        mul_b;
    logic [31:0]        hsat;

    logic               div_start;
    logic               div_busy;
    logic [DVD_W-1:0]   dvd;
    logic [DVS_W-1:0]   dvs;
    logic [DVD_W-1:0]   quot;

    // shared arithmetic terms
    assign w_ins   = hi_reg - lo_reg;
    assign acc_sum = acc_reg + ACW'(rd_reg.mass);
    assign idx_p1  = {1'b0, idx_reg} + (CW+1)'(1);
    assign m_p1    = (CW+1)'(m_reg) + (CW+1)'(1);
    assign sub_h   = prod_reg[63:16];
    assign d_next  = (48'(massm_reg) > sub_h) ? 17'(48'(massm_reg) - sub_h) : 17'd0;
    assign dsum    = {1'b0, da_reg} + {1'b0, dp_reg};
    assign pdiff   = 17'(ACW'(p_reg) - flo_reg);
    assign hsat    = (|quot[DVD_W-1:32]) ? 32'hFFFF_FFFF : quot[31:0];

    // multiplier operand select
    always_comb begin
        case (cmd.op)
            OP_Q_MUL: mul_b = 32'(pdiff);
            OP_M_MUL: mul_b = 32'(da_reg);
            default:  mul_b = rd_reg.height;
        endcase
    end

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        dvd       = prod_reg[DVD_W-1:0];
        dvs       = 32'(massm_reg);
        case (cmd.op)
            OP_INS_START: begin
                div_start = 1'b1;
                dvd       = {16'd0, pr_reg, 16'd0};
                dvs       = w_ins;
            end
            OP_DIV_Q: begin
                div_start = 1'b1;
            end
            OP_DIV_M: begin
                div_start = 1'b1;
                dvs       = 32'(dsum);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // memory port select
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = idx_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_reg;
        case (cmd.op)
            OP_RD_IDX: rd_addr = idx_reg[AW-1:0];
            OP_RD_JM1: rd_addr = AW'(j_reg - CW'(1));
            OP_RD_M:   rd_addr = m_reg;
            OP_RD_MM1: rd_addr = m_reg - AW'(1);
            OP_RD_MP1: rd_addr = m_reg + AW'(1);
            default:   rd_en   = 1'b0;
        endcase
        case (cmd.op)
            OP_SH_WR: begin
                wr_en   = 1'b1;
                wr_addr = j_reg[AW-1:0];
            end
            OP_INS_WR: begin
                wr_en   = 1'b1;
                wr_data = '{lower: lo_reg, upper: hi_reg, mass: pr_reg, height: hsat};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            mval_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_EMIT) begin
                mval_reg <= 1'b1;
            end else if (m_tready) begin
                mval_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CLEAR:  cnt_reg <= '0;
                OP_INS_WR: cnt_reg <= cnt_reg + CW'(1);
                default:   cnt_reg <= cnt_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE: begin
                kind_reg <= kind_t'(s_tuser);
                lo_reg   <= s_tdata[31:0];
                hi_reg   <= s_tdata[63:32];
                pr_reg   <= s_tdata[80:64];
                p_reg    <= s_tdata[97:81];
                res_reg  <= '0;
                st_reg   <= ST_OK;
            end
            OP_SET_ST: st_reg <= cmd.st;
            OP_INS_START: idx_reg <= '0;
            OP_IDX_CLR: begin
                idx_reg <= '0;
                acc_reg <= '0;
                flo_reg <= '0;
            end
            OP_IDX_INC: idx_reg <= idx_reg + CW'(1);
            OP_SH_INIT: j_reg <= cnt_reg;
            OP_SH_WR:   j_reg <= j_reg - CW'(1);
            OP_INS_WR:  res_reg <= 32'(idx_reg);
            OP_Q_ACC: begin
                flo_reg <= acc_reg;
                acc_reg <= acc_sum;
                if (acc_sum < ACW'(p_reg)) begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
            OP_Q_CLAMP: begin
                res_reg <= rd_reg.upper;
                st_reg  <= ST_CLAMPED;
            end
            OP_GRAB: begin
                lowm_reg  <= rd_reg.lower;
                w_reg     <= rd_reg.upper - rd_reg.lower;
                massm_reg <= rd_reg.mass;
                da_reg    <= rd_reg.mass;
                dp_reg    <= rd_reg.mass;
            end
            OP_RES_LOW: begin
                res_reg <= lowm_reg;
                st_reg  <= cmd.st;
            end
            OP_Q_MUL, OP_MUL_H, OP_M_MUL: prod_reg <= 64'(w_reg) * 64'(mul_b);
            OP_RES_ADD: res_reg <= lowm_reg + quot[31:0];
            OP_M_SCAN: begin
                if (idx_reg == '0 || maxh_reg < rd_reg.height) begin
                    m_reg    <= idx_reg[AW-1:0];
                    maxh_reg <= rd_reg.height;
                end
                idx_reg <= idx_reg + CW'(1);
            end
            OP_SUB_A: da_reg <= d_next;
            OP_SUB_P: dp_reg <= d_next;
            OP_EMIT:  mdata_reg <= {st_reg, 5'(cnt_reg), res_reg};
            default:  res_reg <= res_reg;
        endcase
    end

    pdqm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .quotient (quot)
    );

    // status to the controller
    always_comb begin
        sts.kind       = kind_reg;
        sts.full       = cnt_reg == CW'(MAX_INTERVALS);
        sts.empty      = cnt_reg == '0;
        sts.ins_bad    = hi_reg <= lo_reg;
        sts.idx_at_cnt = idx_reg == cnt_reg;
        sts.lo_gt_up   = lo_reg > $signed(rd_reg.upper);
        sts.lo_eq_up   = lo_reg == $signed(rd_reg.upper);
        sts.sh_done    = j_reg == idx_reg;
        sts.q_below    = acc_sum < ACW'(p_reg);
        sts.idx_last   = idx_p1 >= {1'b0, cnt_reg};
        sts.mass_zero  = massm_reg == '0;
        sts.has_prev   = m_reg != '0;
        sts.has_next   = m_p1 < {1'b0, cnt_reg};
        sts.dsum_zero  = dsum == '0;
        sts.div_idle   = !div_busy;
        sts.out_free   = !mval_reg || m_tready;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_INTERVALS))
        else $error("interval count above table depth");
    a_ins_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_INS_WR) |-> (!div_busy && cnt_reg < CW'(MAX_INTERVALS)))
        else $error("insert write without room or before height is ready");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_CLEAR) |=> (cnt_reg == '0))
        else $error("clear did not empty the table");
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

// ----- sv/pdqm_ctrl.sv -----
`default_nettype none
module pdqm_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire pdqm_pkg::sts_t  sts,
    output pdqm_pkg::cmd_t       cmd
);
    import pdqm_pkg::*;

    typedef enum logic [27:0] {
        S_IDLE     = 28'h1 << 0,
        S_DECODE   = 28'h1 << 1,
        S_INS_RD   = 28'h1 << 2,
        S_INS_CMP  = 28'h1 << 3,
        S_SH_INIT  = 28'h1 << 4,
        S_SH_RD    = 28'h1 << 5,
        S_SH_WR    = 28'h1 << 6,
        S_INS_WAIT = 28'h1 << 7,
        S_Q_RD     = 28'h1 << 8,
        S_Q_CMP    = 28'h1 << 9,
        S_Q_CLAMP  = 28'h1 << 10,
        S_Q_LAND   = 28'h1 << 11,
        S_Q_CHK    = 28'h1 << 12,
        S_Q_DIV    = 28'h1 << 13,
        S_DIV_WAIT = 28'h1 << 14,
        S_M_RD     = 28'h1 << 15,
        S_M_CMP    = 28'h1 << 16,
        S_M_RDM    = 28'h1 << 17,
        S_M_GET    = 28'h1 << 18,
        S_M_RDA    = 28'h1 << 19,
        S_M_MULA   = 28'h1 << 20,
        S_M_SUBA   = 28'h1 << 21,
        S_M_RDP    = 28'h1 << 22,
        S_M_MULP   = 28'h1 << 23,
        S_M_SUBP   = 28'h1 << 24,
        S_M_CHK    = 28'h1 << 25,
        S_M_DIV    = 28'h1 << 26,
        S_EMIT     = 28'h1 << 27
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencing and command decode
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.st     = ST_OK;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.kind)
                    KIND_INSERT: begin
                        if (sts.full) begin
                            cmd.op     = OP_SET_ST;
                            cmd.st     = ST_FULL;
                            state_next = S_EMIT;
                        end else if (sts.ins_bad) begin
                            cmd.op     = OP_SET_ST;
                            cmd.st     = ST_ZERODIV;
                            state_next = S_EMIT;
                        end else begin
                            cmd.op     = OP_INS_START;
                            state_next = S_INS_RD;
                        end
                    end
                    KIND_QUANTILE, KIND_MODE: begin
                        if (sts.empty) begin
                            cmd.op     = OP_SET_ST;
                            cmd.st     = ST_EMPTY;
                            state_next = S_EMIT;
                        end else begin
                            cmd.op     = OP_IDX_CLR;
                            state_next = (sts.kind == KIND_MODE) ? S_M_RD : S_Q_RD;
                        end
                    end
                    default: begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_EMIT;
                    end
                endcase
            end
            // insert: find the slot
            S_INS_RD: begin
                if (sts.idx_at_cnt) begin
                    state_next = S_SH_INIT;
                end else begin
                    cmd.op     = OP_RD_IDX;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (sts.lo_gt_up) begin
                    cmd.op     = OP_IDX_INC;
                    state_next = S_INS_RD;
                end else if (sts.lo_eq_up) begin
                    cmd.op     = OP_IDX_INC;
                    state_next = S_SH_INIT;
                end else begin
                    state_next = S_SH_INIT;
                end
            end
            // insert: move later entries up one place
            S_SH_INIT: begin
                cmd.op     = OP_SH_INIT;
                state_next = S_SH_RD;
            end
            S_SH_RD: begin
                if (sts.sh_done) begin
                    state_next = S_INS_WAIT;
                end else begin
                    cmd.op     = OP_RD_JM1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.op     = OP_SH_WR;
                state_next = S_SH_RD;
            end
            S_INS_WAIT: begin
                if (sts.div_idle) begin
                    cmd.op     = OP_INS_WR;
                    state_next = S_EMIT;
                end
            end
            // quantile: cumulative mass walk
            S_Q_RD: begin
                cmd.op     = OP_RD_IDX;
                state_next = S_Q_CMP;
            end
            S_Q_CMP: begin
                cmd.op = OP_Q_ACC;
                if (sts.q_below && sts.idx_last) begin
                    state_next = S_Q_CLAMP;
                end else if (sts.q_below) begin
                    state_next = S_Q_RD;
                end else begin
                    state_next = S_Q_LAND;
                end
            end
            S_Q_CLAMP: begin
                cmd.op     = OP_Q_CLAMP;
                state_next = S_EMIT;
            end
            S_Q_LAND: begin
                cmd.op     = OP_GRAB;
                state_next = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (sts.mass_zero) begin
                    cmd.op     = OP_RES_LOW;
                    cmd.st     = ST_ZERODIV;
                    state_next = S_EMIT;
                end else begin
                    cmd.op     = OP_Q_MUL;
                    state_next = S_Q_DIV;
                end
            end
            S_Q_DIV: begin
                cmd.op     = OP_DIV_Q;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (sts.div_idle) begin
                    cmd.op     = OP_RES_ADD;
                    state_next = S_EMIT;
                end
            end
            // mode: tallest interval, first one wins
            S_M_RD: begin
                cmd.op     = OP_RD_IDX;
                state_next = S_M_CMP;
            end
            S_M_CMP: begin
                cmd.op     = OP_M_SCAN;
                state_next = sts.idx_last ? S_M_RDM : S_M_RD;
            end
            S_M_RDM: begin
                cmd.op     = OP_RD_M;
                state_next = S_M_GET;
            end
            S_M_GET: begin
                cmd.op = OP_GRAB;
                if (sts.has_prev) begin
                    state_next = S_M_RDA;
                end else if (sts.has_next) begin
                    state_next = S_M_RDP;
                end else begin
                    state_next = S_M_CHK;
                end
            end
            S_M_RDA: begin
                cmd.op     = OP_RD_MM1;
                state_next = S_M_MULA;
            end
            S_M_MULA: begin
                cmd.op     = OP_MUL_H;
                state_next = S_M_SUBA;
            end
            S_M_SUBA: begin
                cmd.op     = OP_SUB_A;
                state_next = sts.has_next ? S_M_RDP : S_M_CHK;
            end
            S_M_RDP: begin
                cmd.op     = OP_RD_MP1;
                state_next = S_M_MULP;
            end
            S_M_MULP: begin
                cmd.op     = OP_MUL_H;
                state_next = S_M_SUBP;
            end
            S_M_SUBP: begin
                cmd.op     = OP_SUB_P;
                state_next = S_M_CHK;
            end
            S_M_CHK: begin
                if (sts.dsum_zero) begin
                    cmd.op     = OP_RES_LOW;
                    cmd.st     = ST_ZERODIV;
                    state_next = S_EMIT;
                end else begin
                    cmd.op     = OP_M_MUL;
                    state_next = S_M_DIV;
                end
            end
            S_M_DIV: begin
                cmd.op     = OP_DIV_M;
                state_next = S_DIV_WAIT;
            end
            // hand the result to the output register
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
